// ===== rtl/core/fprt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed-point radix to text: shared package
// Payload types for the channel interface, and register indexes and
// character constants used by the converter core.
// ----------------------------------------------------------------------------
package fprt_pkg;

  // Port field widths; these are fixed by the interface definition.
  localparam int unsigned WHOLE_W  = 31;
  localparam int unsigned FRAC_W   = 32;
  localparam int unsigned RADIX_W  = 6;
  localparam int unsigned PREC_W   = 5;
  localparam int unsigned CHAR_W   = 7;
  localparam int unsigned CFG_IDX_W = 2;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_RADIX       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAC_DIGITS = 2'd1;

  // Register reset values and radix limits.
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [PREC_W-1:0]  PREC_RESET  = 5'd6;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  // ASCII codes.
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_POINT = 7'h2E;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  // 'A' minus ten, so that digit ten maps onto 'A'.
  localparam logic [CHAR_W-1:0] CHAR_ALPHA_BASE = 7'h37;

  typedef struct packed {
    logic              is_negative;
    logic [WHOLE_W-1:0] whole_part;
    logic [FRAC_W-1:0]  fraction_part;
  } in_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              is_last;
  } out_req_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [RADIX_W-1:0]   data;
  } cfg_req_t;

  // Maps a digit value 0..35 onto '0'..'9', 'A'..'Z'.
  function automatic logic [CHAR_W-1:0] digit_char(logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {1'b0, d};
    if (d < 6'd10) begin
      return CHAR_ZERO + d_ext;
    end
    return CHAR_ALPHA_BASE + d_ext;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/fprt_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed-point radix to text: valid/ready channel
// One request channel with a generic payload type.
// ----------------------------------------------------------------------------
interface fprt_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/fixed_point_radix_to_text.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed-point radix to text converter
// Writes a signed Q31.32 magnitude as ASCII characters in base 2 to 36.
// ----------------------------------------------------------------------------
// One input request is a sign, an integer magnitude and a binary fraction.
// The block answers with a stream of character requests: an optional '-'
// (never for zero), the integer digits most significant first (at least
// one), and, when fraction_digits is nonzero, a '.' and that many fraction
// digits, truncated. The final character carries is_last. Integer digits
// come from a restoring divider that retires one quotient bit per cycle,
// one full pass over the WHOLE_BITS dividend bits per integer digit;
// fraction digits come from one multiply per cycle while the output
// side is free to take a character. The input channel is ready only
// while the sequencer is idle; a finished character sits in an output
// register, so the next number can be taken while the last character of
// the previous one waits. Configuration writes are always accepted and
// take effect for the next accepted number. Radix values outside 2..36
// are clamped, and fraction_digits is clamped to MAX_FRAC_DIGITS. Input
// bits above WHOLE_BITS and FRAC_BITS are ignored.
// ----------------------------------------------------------------------------
module fixed_point_radix_to_text #(
  parameter int unsigned WHOLE_BITS      = 31,
  parameter int unsigned FRAC_BITS       = 32,
  parameter int unsigned MAX_FRAC_DIGITS = 31
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  fprt_stream_if.sink    in_i,
  fprt_stream_if.source  out_o,
  fprt_stream_if.sink    cfg_i
);

  localparam int unsigned RW     = fprt_pkg::RADIX_W;
  localparam int unsigned PW     = fprt_pkg::PREC_W;
  localparam int unsigned BIT_W  = $clog2(WHOLE_BITS);
  localparam int unsigned CNT_W  = $clog2(WHOLE_BITS + 1);
  localparam int unsigned IDX_W  = $clog2(WHOLE_BITS);
  localparam int unsigned PROD_W = FRAC_BITS + RW;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_SIGN  = 3'd2;
  localparam logic [2:0] ST_POP   = 3'd3;
  localparam logic [2:0] ST_POINT = 3'd4;
  localparam logic [2:0] ST_FRAC  = 3'd5;

  logic [2:0] state_q, state_d;

  // Configuration registers.
  logic [RW-1:0] radix_q;
  logic [PW-1:0] frac_digits_q;

  // Working registers for one number.
  logic [WHOLE_BITS-1:0] whole_q, whole_d;   // dividend, then quotient
  logic [RW-1:0]         rem_q, rem_d;       // partial remainder, below base
  logic [BIT_W-1:0]      bit_q, bit_d;       // divider bit position
  logic [CNT_W-1:0]      cnt_q, cnt_d;       // digits on the stack
  logic [FRAC_BITS-1:0]  frac_q, frac_d;
  logic [RW-1:0]         base_q, base_d;
  logic [PW-1:0]         prec_q, prec_d;
  logic                  neg_q, neg_d;

  // Integer digit stack, least significant digit at the bottom.
  logic [RW-1:0] stack_q [WHOLE_BITS];

  // Output register.
  logic                             out_valid_q;
  logic [fprt_pkg::CHAR_W-1:0]      out_char_q;
  logic                             out_last_q;

  // Shared divider step and fraction multiply.
  logic [RW:0]           trial;
  logic [RW:0]           diff;
  logic                  ge;
  logic [RW-1:0]         rem_nx;
  logic [WHOLE_BITS-1:0] quo_nx;
  logic [PROD_W-1:0]     prod;
  logic [CNT_W-1:0]      cnt_m1;
  logic [RW-1:0]         stack_top;

  logic                        in_fire;
  logic                        out_free;
  logic                        push;
  logic                        emit;
  logic [fprt_pkg::CHAR_W-1:0] emit_char;
  logic                        emit_last;

  logic [WHOLE_BITS-1:0] in_whole;
  logic [FRAC_BITS-1:0]  in_frac;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign out_o.valid             = out_valid_q;
  assign out_o.payload.char_code = out_char_q;
  assign out_o.payload.is_last   = out_last_q;
  assign out_free = !out_valid_q || out_o.ready;

  assign in_whole = in_i.payload.whole_part[WHOLE_BITS-1:0];
  assign in_frac  = in_i.payload.fraction_part[FRAC_BITS-1:0];

  // One restoring division step: shift in the next dividend bit and
  // subtract the base when it fits.
  assign trial  = {rem_q, whole_q[WHOLE_BITS-1]};
  assign ge     = (trial >= {1'b0, base_q});
  assign diff   = trial - {1'b0, base_q};
  assign rem_nx = ge ? diff[RW-1:0] : trial[RW-1:0];
  assign quo_nx = {whole_q[WHOLE_BITS-2:0], ge};

  // The bits above the binary point are the next fraction digit.
  assign prod = PROD_W'(frac_q) * PROD_W'(base_q);

  assign cnt_m1    = cnt_q - CNT_W'(1);
  assign stack_top = stack_q[cnt_m1[IDX_W-1:0]];

  always_comb begin
    state_d   = state_q;
    whole_d   = whole_q;
    rem_d     = rem_q;
    bit_d     = bit_q;
    cnt_d     = cnt_q;
    frac_d    = frac_q;
    base_d    = base_q;
    prec_d    = prec_q;
    neg_d     = neg_q;
    push      = 1'b0;
    emit      = 1'b0;
    emit_char = fprt_pkg::CHAR_ZERO;
    emit_last = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          whole_d = in_whole;
          frac_d  = in_frac;
          // Negative zero prints without a sign.
          neg_d   = in_i.payload.is_negative && ((|in_whole) || (|in_frac));
          if (radix_q < fprt_pkg::RADIX_MIN) begin
            base_d = fprt_pkg::RADIX_MIN;
          end else if (radix_q > fprt_pkg::RADIX_MAX) begin
            base_d = fprt_pkg::RADIX_MAX;
          end else begin
            base_d = radix_q;
          end
          if (frac_digits_q > PW'(MAX_FRAC_DIGITS)) begin
            prec_d = PW'(MAX_FRAC_DIGITS);
          end else begin
            prec_d = frac_digits_q;
          end
          rem_d   = '0;
          bit_d   = BIT_W'(WHOLE_BITS - 1);
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d   = rem_nx;
        whole_d = quo_nx;
        bit_d   = bit_q - BIT_W'(1);
        if (bit_q == '0) begin
          // Division done: the remainder is the next digit.
          push  = 1'b1;
          cnt_d = cnt_q + CNT_W'(1);
          rem_d = '0;
          bit_d = BIT_W'(WHOLE_BITS - 1);
          if (quo_nx == '0) begin
            state_d = ST_SIGN;
          end
        end
      end
      ST_SIGN: begin
        if (!neg_q) begin
          state_d = ST_POP;
        end else if (out_free) begin
          emit      = 1'b1;
          emit_char = fprt_pkg::CHAR_MINUS;
          state_d   = ST_POP;
        end
      end
      ST_POP: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = fprt_pkg::digit_char(stack_top);
          cnt_d     = cnt_m1;
          if (cnt_q == CNT_W'(1)) begin
            if (prec_q == '0) begin
              emit_last = 1'b1;
              state_d   = ST_IDLE;
            end else begin
              state_d = ST_POINT;
            end
          end
        end
      end
      ST_POINT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = fprt_pkg::CHAR_POINT;
          state_d   = ST_FRAC;
        end
      end
      ST_FRAC: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = fprt_pkg::digit_char(prod[FRAC_BITS +: RW]);
          frac_d    = prod[FRAC_BITS-1:0];
          prec_d    = prec_q - PW'(1);
          if (prec_q == PW'(1)) begin
            emit_last = 1'b1;
            state_d   = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
      radix_q       <= fprt_pkg::RADIX_RESET;
      frac_digits_q <= fprt_pkg::PREC_RESET;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        unique case (cfg_i.payload.index)
          fprt_pkg::REG_RADIX: begin
            radix_q <= cfg_i.payload.data;
          end
          fprt_pkg::REG_FRAC_DIGITS: begin
            frac_digits_q <= cfg_i.payload.data[PW-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    whole_q <= whole_d;
    rem_q   <= rem_d;
    bit_q   <= bit_d;
    frac_q  <= frac_d;
    base_q  <= base_d;
    prec_q  <= prec_d;
    neg_q   <= neg_d;
    if (push) begin
      stack_q[cnt_q[IDX_W-1:0]] <= rem_nx;
    end
    if (emit) begin
      out_char_q <= emit_char;
      out_last_q <= emit_last;
    end
  end

`ifndef NO_ASSERTIONS
  // The stack never holds more digits than the integer part can have.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(WHOLE_BITS))
    else $error("digit count exceeds stack depth");

  // Popping only happens with digits on the stack.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_POP |-> cnt_q != '0)
    else $error("pop from empty digit stack");

  // The partial remainder stays below the base throughout a division.
  a_rem_below_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_q < base_q)
    else $error("divider remainder out of range");

  // An accepted number starts the divider on the next cycle.
  a_accept_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_DIV && cnt_q == '0)
    else $error("accepted number did not start division");

  // The last character of a number returns the sequencer to idle.
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && emit_last |=> state_q == ST_IDLE && out_valid_q && out_last_q)
    else $error("final character did not end the number");
`endif

endmodule
`default_nettype wire

// ===== test/tb_fixed_point_radix_to_text.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point radix to text: self-checking testbench
// Drives signed Q31.32 numbers into the converter under a series of radix
// and precision settings. It predicts the character stream of each accepted
// number and compares every character and last flag as it leaves the block.
// ----------------------------------------------------------------------------
module tb_fixed_point_radix_to_text;

  localparam int unsigned WHOLE_W   = fprt_pkg::WHOLE_W;
  localparam int unsigned FRAC_W    = fprt_pkg::FRAC_W;
  localparam int unsigned RADIX_W   = fprt_pkg::RADIX_W;
  localparam int unsigned PREC_W    = fprt_pkg::PREC_W;
  localparam int unsigned CHAR_W    = fprt_pkg::CHAR_W;
  localparam int unsigned CFG_IDX_W = fprt_pkg::CFG_IDX_W;

  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam logic [CHAR_W-1:0] GLYPH_DIGIT0 = 7'h30;
  localparam logic [CHAR_W-1:0] GLYPH_A      = 7'h41;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #5 clk_i = ~clk_i;

  fprt_stream_if #(.payload_t(fprt_pkg::in_req_t))  in_if  ();
  fprt_stream_if #(.payload_t(fprt_pkg::out_req_t)) out_if ();
  fprt_stream_if #(.payload_t(fprt_pkg::cfg_req_t)) cfg_if ();

  fixed_point_radix_to_text u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Shadow copies of the format registers.
  logic [RADIX_W-1:0] radix_reg       = fprt_pkg::RADIX_RESET;
  logic [PREC_W-1:0]  frac_digits_reg = fprt_pkg::PREC_RESET;

  fprt_pkg::in_req_t  pending[$];
  fprt_pkg::out_req_t expected_chars[$];
  fprt_pkg::in_req_t  cur_item;
  bit          in_busy = 1'b0;
  int          in_gap = 0;
  int          out_stall = 0;
  bit          in_taken = 1'b0;
  bit          out_taken = 1'b0;
  bit          idle_on = 1'b1;
  int unsigned cycle_cnt = 0;
  int unsigned err_cnt = 0;

  function automatic logic [CHAR_W-1:0] glyph(input logic [RADIX_W-1:0] d);
    if (d < 10) begin
      return GLYPH_DIGIT0 + CHAR_W'(d);
    end
    return GLYPH_A + CHAR_W'(d) - CHAR_W'(10);
  endfunction

  // Builds the full text of one number and queues it as expected characters.
  function automatic void predict_text(input fprt_pkg::in_req_t num);
    logic [RADIX_W-1:0] base;
    logic [WHOLE_W-1:0] whole;
    logic [FRAC_W-1:0]  frac;
    logic [63:0]        prod;
    logic [RADIX_W-1:0] d;
    logic [RADIX_W-1:0] digits[$];
    fprt_pkg::out_req_t text[$];
    fprt_pkg::out_req_t c;
    base  = (radix_reg < 2) ? 6'd2 : (radix_reg > 36) ? 6'd36 : radix_reg;
    whole = num.whole_part;
    frac  = num.fraction_part;
    c.is_last = 1'b0;
    // A negative zero prints without its sign.
    if (num.is_negative && (whole != 0 || frac != 0)) begin
      c.char_code = fprt_pkg::CHAR_MINUS;
      text.push_back(c);
    end
    do begin
      d = whole % base;
      digits.push_front(d);
      whole = whole / base;
    end while (whole != 0);
    foreach (digits[i]) begin
      c.char_code = glyph(digits[i]);
      text.push_back(c);
    end
    if (frac_digits_reg != 0) begin
      c.char_code = fprt_pkg::CHAR_POINT;
      text.push_back(c);
      for (int i = 0; i < int'(frac_digits_reg); i++) begin
        prod = 64'(frac) * 64'(base);
        d    = prod[37:32];
        frac = prod[31:0];
        c.char_code = glyph(d);
        text.push_back(c);
      end
    end
    text[text.size()-1].is_last = 1'b1;
    foreach (text[i]) begin
      expected_chars.push_back(text[i]);
    end
  endfunction

  function automatic void check_char(input fprt_pkg::out_req_t got);
    fprt_pkg::out_req_t want;
    if (expected_chars.size() == 0) begin
      err_cnt++;
      $display("%0t: unexpected character: expected none, actual %h last %b",
               $time, got.char_code, got.is_last);
      return;
    end
    want = expected_chars.pop_front();
    if (got.char_code !== want.char_code) begin
      err_cnt++;
      $display("%0t: char_code mismatch: expected %h, actual %h",
               $time, want.char_code, got.char_code);
    end
    if (got.is_last !== want.is_last) begin
      err_cnt++;
      $display("%0t: is_last mismatch: expected %b, actual %b",
               $time, want.is_last, got.is_last);
    end
  endfunction

  // Sampling side: checks characters, predicts accepted numbers, tracks
  // register writes and guards the run time.
  always @(posedge clk_i) begin
    in_taken  <= rst_ni && in_if.valid && in_if.ready;
    out_taken <= rst_ni && out_if.valid && out_if.ready;
    if (rst_ni) begin
      cycle_cnt <= cycle_cnt + 1;
      if (out_if.valid && out_if.ready) begin
        check_char(out_if.payload);
      end
      if (in_if.valid && in_if.ready) begin
        predict_text(in_if.payload);
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.payload.index)
          fprt_pkg::REG_RADIX:       radix_reg       = cfg_if.payload.data;
          fprt_pkg::REG_FRAC_DIGITS: frac_digits_reg = cfg_if.payload.data[PREC_W-1:0];
          default: ;
        endcase
      end
      if (cycle_cnt >= CYCLE_LIMIT) begin
        $display("[fixed_point_radix_to_text] ERROR");
        $finish;
      end
    end
  end

  // Number sender, fed from the pending queue.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_busy && in_taken) begin
        in_busy = 1'b0;
        in_gap  = idle_on ? $urandom_range(0, 3) : 0;
      end
      if (!in_busy) begin
        if (in_gap != 0) begin
          in_gap--;
        end else if (pending.size() != 0) begin
          cur_item = pending.pop_front();
          in_busy  = 1'b1;
        end
      end
      in_if.valid   <= in_busy;
      in_if.payload <= cur_item;
    end
  end

  // Character receiver with a random stall before each character while idle_on is set.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        out_stall = idle_on ? $urandom_range(0, 3) : 0;
      end
      if (out_stall != 0) begin
        out_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  function automatic fprt_pkg::in_req_t mk_num(input bit neg, input logic [WHOLE_W-1:0] w,
                                               input logic [FRAC_W-1:0] f);
    fprt_pkg::in_req_t n;
    n.is_negative   = neg;
    n.whole_part    = w;
    n.fraction_part = f;
    return n;
  endfunction

  // Mostly short integer parts keep base 2 conversions affordable.
  function automatic fprt_pkg::in_req_t rand_num();
    logic [WHOLE_W-1:0] w;
    logic [FRAC_W-1:0]  f;
    case ($urandom_range(0, 7))
      0:       w = '0;
      1, 2:    w = WHOLE_W'($urandom());
      3:       w = '1;
      default: w = WHOLE_W'($urandom() >> $urandom_range(1, 31));
    endcase
    case ($urandom_range(0, 5))
      0:       f = '0;
      1:       f = '1;
      2:       f = $urandom() >> $urandom_range(1, 31);
      default: f = $urandom();
    endcase
    return mk_num(1'($urandom()), w, f);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RADIX_W-1:0] val);
    @(negedge clk_i);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= '{index: idx, data: val};
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  task automatic set_format(input logic [RADIX_W-1:0] r, input logic [RADIX_W-1:0] p);
    write_reg(fprt_pkg::REG_RADIX, r);
    write_reg(fprt_pkg::REG_FRAC_DIGITS, p);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending.size() != 0 || in_busy || expected_chars.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    logic [RADIX_W-1:0] r;
    logic [RADIX_W-1:0] p;
    bit                 pause;
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    out_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    cur_item       = '0;
    rst_ni         = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed numbers at the reset format, base ten with six digits.
    pending.push_back(mk_num(1'b0, '0, '0));
    pending.push_back(mk_num(1'b1, '0, '0));
    pending.push_back(mk_num(1'b1, '0, 32'd1));
    pending.push_back(mk_num(1'b1, '1, '1));
    pending.push_back(mk_num(1'b0, '1, '0));
    pending.push_back(mk_num(1'b0, 31'd1, 32'h8000_0000));
    pending.push_back(mk_num(1'b0, '0, '1));
    pending.push_back(mk_num(1'b1, 31'd123456, 32'h1999_999A));
    wait_drained();

    // Radix below the range acts as base two; longest fraction.
    set_format(6'd0, 6'd31);
    pending.push_back(mk_num(1'b1, '1, '1));
    pending.push_back(mk_num(1'b0, '0, 32'd1));
    wait_drained();

    // Radix above the range acts as base 36; no point.
    set_format(6'd63, 6'd0);
    pending.push_back(mk_num(1'b0, '1, '1));
    pending.push_back(mk_num(1'b1, 31'd35, '0));
    pending.push_back(mk_num(1'b1, '0, 32'hDEAD_BEEF));
    pending.push_back(mk_num(1'b0, '0, '0));
    wait_drained();

    // Radix one acts as two; the precision write drops its top data bit.
    set_format(6'd1, 6'h21);
    repeat (5) pending.push_back(rand_num());
    wait_drained();

    set_format(6'd37, 6'd31);
    pending.push_back(mk_num(1'b1, '1, '1));
    pending.push_back(mk_num(1'b0, 31'd1295, 32'h0000_FFFF));
    wait_drained();

    for (int ph = 0; ph < 16; ph++) begin
      case ($urandom_range(0, 7))
        0:       r = 6'd2;
        1:       r = 6'd36;
        2:       r = 6'($urandom_range(0, 63));
        default: r = 6'($urandom_range(2, 36));
      endcase
      case ($urandom_range(0, 5))
        0:       p = 6'd0;
        1:       p = 6'd31;
        2:       p = 6'($urandom_range(32, 63));
        default: p = 6'($urandom_range(0, 31));
      endcase
      idle_on = (ph == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      pause   = (ph == 1) || ($urandom_range(0, 3) == 0);
      set_format(r, p);
      for (int k = 0; k < 31; k++) begin
        pending.push_back(rand_num());
        // Hold the sender back until the block has said everything.
        if (k == 15 && pause) begin
          wait_drained();
        end
      end
      wait_drained();
    end

    repeat (50) @(negedge clk_i);
    if (expected_chars.size() != 0) begin
      err_cnt++;
      $display("%0t: characters missing: expected %0d more, actual 0",
               $time, expected_chars.size());
    end
    if (err_cnt == 0) begin
      $display("[fixed_point_radix_to_text] OK");
    end else begin
      $display("[fixed_point_radix_to_text] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/fprt_pkg.sv
rtl/core/fprt_stream_if.sv
rtl/core/fixed_point_radix_to_text.sv
test/tb_fixed_point_radix_to_text.sv
